### rtl/xcfp_pkg.sv
// shared constants, controller states and command/status structs for the frame parser
`timescale 1ns / 1ps

package xcfp_pkg;

   localparam int MAX_PAYLOAD = 32;
   localparam int PAY_AW      = $clog2(MAX_PAYLOAD);
   localparam int LEN_W       = 6;
   localparam logic [7:0] START_RESET = 8'h01;

   typedef enum logic [3:0] {
      ST_HUNT,
      ST_ID_H,
      ST_ID_L,
      ST_LEN_H,
      ST_LEN_L,
      ST_KIND_H,
      ST_KIND_L,
      ST_HCHK,
      ST_DATA,
      ST_DCHK,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   typedef struct packed {
      logic hdr_start;
      logic hdr_acc;
      logic id_hi;
      logic id_lo;
      logic len_hi;
      logic len_lo;
      logic kind_hi;
      logic kind_lo;
      logic pay_clear;
      logic pay_wr;
      logic chk_data;
      logic bad_inc;
      logic emit_clear;
      logic emit_rd;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic is_start;
      logic len_bad;
      logic hdr_ok;
      logic fill_last;
      logic len_zero;
      logic emit_last;
      logic out_free;
   } status_type;

endpackage

### rtl/xcfp_ctrl.sv
// controller state machine: walks the frame fields and sequences result emission
`timescale 1ns / 1ps

module xcfp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  xcfp_pkg::status_type sts,
   output xcfp_pkg::cmd_type    cmd
);
   import xcfp_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      beat;

   assign req_ready = (state_ff != ST_EMIT_RD) && (state_ff != ST_EMIT_LD);
   assign beat      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_HUNT: begin
            if (beat && sts.is_start) begin
               cmd.hdr_start = 1'b1;
               state_in      = ST_ID_H;
            end
         end
         ST_ID_H: begin
            if (beat) begin
               cmd.hdr_acc = 1'b1;
               cmd.id_hi   = 1'b1;
               state_in    = ST_ID_L;
            end
         end
         ST_ID_L: begin
            if (beat) begin
               cmd.hdr_acc = 1'b1;
               cmd.id_lo   = 1'b1;
               state_in    = ST_LEN_H;
            end
         end
         ST_LEN_H: begin
            if (beat) begin
               cmd.hdr_acc = 1'b1;
               cmd.len_hi  = 1'b1;
               state_in    = ST_LEN_L;
            end
         end
         ST_LEN_L: begin
            if (beat) begin
               cmd.hdr_acc = 1'b1;
               // oversize length drops the header, low byte not rechecked as start
               if (sts.len_bad) begin
                  cmd.bad_inc = 1'b1;
                  state_in    = ST_HUNT;
               end else begin
                  cmd.len_lo = 1'b1;
                  state_in   = ST_KIND_H;
               end
            end
         end
         ST_KIND_H: begin
            if (beat) begin
               cmd.hdr_acc = 1'b1;
               cmd.kind_hi = 1'b1;
               state_in    = ST_KIND_L;
            end
         end
         ST_KIND_L: begin
            if (beat) begin
               cmd.hdr_acc = 1'b1;
               cmd.kind_lo = 1'b1;
               state_in    = ST_HCHK;
            end
         end
         ST_HCHK: begin
            if (beat) begin
               if (sts.hdr_ok) begin
                  cmd.pay_clear = 1'b1;
                  state_in      = sts.len_zero ? ST_DCHK : ST_DATA;
               end else begin
                  cmd.bad_inc = 1'b1;
                  // a bad checksum byte equal to the start byte opens a new header
                  if (sts.is_start) begin
                     cmd.hdr_start = 1'b1;
                     state_in      = ST_ID_H;
                  end else begin
                     state_in = ST_HUNT;
                  end
               end
            end
         end
         ST_DATA: begin
            if (beat) begin
               cmd.pay_wr = 1'b1;
               if (sts.fill_last) begin
                  state_in = ST_DCHK;
               end
            end
         end
         ST_DCHK: begin
            if (beat) begin
               cmd.chk_data   = 1'b1;
               cmd.emit_clear = 1'b1;
               state_in       = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = sts.emit_last ? ST_HUNT : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

endmodule

### rtl/xcfp_dpath.sv
// datapath: header fields, checksums, payload buffer, counters and result register
`timescale 1ns / 1ps

module xcfp_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data,
   input  logic [7:0]           req_rx_byte,
   input  xcfp_pkg::cmd_type    cmd,
   output xcfp_pkg::status_type sts,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [15:0]          rsp_frame_ident,
   output logic [15:0]          rsp_frame_kind,
   output logic [5:0]           rsp_payload_length,
   output logic [7:0]           rsp_payload_byte,
   output logic [4:0]           rsp_payload_index,
   output logic                 rsp_payload_valid,
   output logic                 rsp_data_check_ok,
   output logic                 rsp_last_of_frame,
   output logic [31:0]          rsp_good_frames,
   output logic [31:0]          rsp_bad_events
);
   import xcfp_pkg::*;

   logic [7:0]        start_ff;
   logic [7:0]        hxor_ff;
   logic [15:0]       ident_ff;
   logic [15:0]       kind_ff;
   logic [LEN_W-1:0]  length_ff;
   logic              len_high_ff;
   logic [LEN_W-1:0]  fill_ff;
   logic [7:0]        pxor_ff;
   logic              ok_ff;
   logic [31:0]       good_ff;
   logic [31:0]       bad_ff;
   logic [PAY_AW-1:0] emit_ff;
   logic [7:0]        rd_data_ff;
   logic [7:0]        mem [MAX_PAYLOAD];

   logic              out_valid_ff;
   logic [15:0]       out_ident_ff;
   logic [15:0]       out_kind_ff;
   logic [LEN_W-1:0]  out_length_ff;
   logic [7:0]        out_byte_ff;
   logic [PAY_AW-1:0] out_index_ff;
   logic              out_pvalid_ff;
   logic              out_ok_ff;
   logic              out_last_ff;
   logic [31:0]       out_good_ff;
   logic [31:0]       out_bad_ff;

   logic              data_ok;
   logic              len_zero;

   assign data_ok  = (~pxor_ff) == req_rx_byte;
   assign len_zero = length_ff == '0;

   assign sts.is_start  = req_rx_byte == start_ff;
   assign sts.len_bad   = len_high_ff || (req_rx_byte > 8'(MAX_PAYLOAD));
   assign sts.hdr_ok    = (~hxor_ff) == req_rx_byte;
   assign sts.fill_last = (fill_ff + LEN_W'(1)) >= length_ff;
   assign sts.len_zero  = len_zero;
   assign sts.emit_last = len_zero || ((LEN_W'(emit_ff) + LEN_W'(1)) == length_ff);
   assign sts.out_free  = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RESET;
         good_ff  <= '0;
         bad_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            start_ff <= csr_wr_data;
         end
         if (cmd.chk_data && data_ok) begin
            good_ff <= good_ff + 32'd1;
         end
         if (cmd.bad_inc || (cmd.chk_data && !data_ok)) begin
            bad_ff <= bad_ff + 32'd1;
         end
      end
   end

   // header and payload bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.hdr_start) begin
         hxor_ff <= req_rx_byte;
      end else if (cmd.hdr_acc) begin
         hxor_ff <= hxor_ff ^ req_rx_byte;
      end
      if (cmd.id_hi) begin
         ident_ff[15:8] <= req_rx_byte;
      end
      if (cmd.id_lo) begin
         ident_ff[7:0] <= req_rx_byte;
      end
      if (cmd.len_hi) begin
         len_high_ff <= req_rx_byte != 8'd0;
      end
      if (cmd.len_lo) begin
         length_ff <= req_rx_byte[LEN_W-1:0];
      end
      if (cmd.kind_hi) begin
         kind_ff[15:8] <= req_rx_byte;
      end
      if (cmd.kind_lo) begin
         kind_ff[7:0] <= req_rx_byte;
      end
      if (cmd.pay_clear) begin
         fill_ff <= '0;
         pxor_ff <= '0;
      end else if (cmd.pay_wr) begin
         fill_ff <= fill_ff + LEN_W'(1);
         pxor_ff <= pxor_ff ^ req_rx_byte;
      end
      if (cmd.chk_data) begin
         ok_ff <= data_ok;
      end
      if (cmd.emit_clear) begin
         emit_ff <= '0;
      end else if (cmd.out_load) begin
         emit_ff <= emit_ff + PAY_AW'(1);
      end
   end

   // payload buffer
   always_ff @(posedge clock) begin
      if (cmd.pay_wr) begin
         mem[fill_ff[PAY_AW-1:0]] <= req_rx_byte;
      end
      if (cmd.emit_rd) begin
         rd_data_ff <= mem[emit_ff];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ident_ff  <= ident_ff;
         out_kind_ff   <= kind_ff;
         out_length_ff <= length_ff;
         out_byte_ff   <= len_zero ? 8'd0 : rd_data_ff;
         out_index_ff  <= len_zero ? '0 : emit_ff;
         out_pvalid_ff <= !len_zero;
         out_ok_ff     <= sts.emit_last && ok_ff;
         out_last_ff   <= sts.emit_last;
         out_good_ff   <= good_ff;
         out_bad_ff    <= bad_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_frame_ident    = out_ident_ff;
   assign rsp_frame_kind     = out_kind_ff;
   assign rsp_payload_length = out_length_ff;
   assign rsp_payload_byte   = out_byte_ff;
   assign rsp_payload_index  = out_index_ff;
   assign rsp_payload_valid  = out_pvalid_ff;
   assign rsp_data_check_ok  = out_ok_ff;
   assign rsp_last_of_frame  = out_last_ff;
   assign rsp_good_frames    = out_good_ff;
   assign rsp_bad_events     = out_bad_ff;

endmodule

### rtl/xor_checked_frame_parser_top.sv
// top level of the byte-serial frame parser with xor header and data checksums
//
//   port group  direction  handshake          carries
//   req_        in         req_valid/ready    rx_byte, one received byte per beat
//   rsp_        out        rsp_valid/ready    one payload byte of a frame plus header,
//                                             verdict and counters per beat
//   csr_        in         csr_wr_en          start_byte, no wait, no read-back
//
// every header and payload byte, and the checksum bytes, are taken one per cycle.
// after the data checksum byte the frame goes out one result at a time, each a buffer
// read, then a load of the result register that waits while a result is held and
// rsp_ready is low; no byte is taken during that run.
// reset is synchronous; the payload buffer needs no clearing pass.
// the result register lets the next frame's bytes come in while a result waits.
`timescale 1ns / 1ps

module xor_checked_frame_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_frame_ident,
   output logic [15:0] rsp_frame_kind,
   output logic [5:0]  rsp_payload_length,
   output logic [7:0]  rsp_payload_byte,
   output logic [4:0]  rsp_payload_index,
   output logic        rsp_payload_valid,
   output logic        rsp_data_check_ok,
   output logic        rsp_last_of_frame,
   output logic [31:0] rsp_good_frames,
   output logic [31:0] rsp_bad_events
);
   import xcfp_pkg::*;

   cmd_type    cmd;
   status_type sts;

   xcfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   xcfp_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_rx_byte        (req_rx_byte),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_ident    (rsp_frame_ident),
      .rsp_frame_kind     (rsp_frame_kind),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_payload_valid  (rsp_payload_valid),
      .rsp_data_check_ok  (rsp_data_check_ok),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .rsp_good_frames    (rsp_good_frames),
      .rsp_bad_events     (rsp_bad_events)
   );

endmodule

### rtl/xcfp_checker.sv
// port-level checks on the frame parser results, bound to the top level
`timescale 1ns / 1ps

module xcfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_frame_ident,
   input logic [5:0]  rsp_payload_length,
   input logic [7:0]  rsp_payload_byte,
   input logic [4:0]  rsp_payload_index,
   input logic        rsp_payload_valid,
   input logic        rsp_data_check_ok,
   input logic        rsp_last_of_frame
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload_byte)
         && $stable(rsp_payload_index) && $stable(rsp_frame_ident))
      else $error("result beat changed while stalled");

   // a zero-length frame is a single, final beat
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_valid |-> rsp_last_of_frame && rsp_payload_byte == 8'd0)
      else $error("zero-length frame beat not final");

   // verdict only on the final beat
   a_ok_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_frame |-> !rsp_data_check_ok)
      else $error("checksum verdict before last beat");

   // payload position stays inside the frame length
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_valid |-> {1'b0, rsp_payload_index} < rsp_payload_length)
      else $error("payload index beyond frame length");

endmodule

bind xor_checked_frame_parser_top xcfp_checker u_xcfp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_frame_ident    (rsp_frame_ident),
   .rsp_payload_length (rsp_payload_length),
   .rsp_payload_byte   (rsp_payload_byte),
   .rsp_payload_index  (rsp_payload_index),
   .rsp_payload_valid  (rsp_payload_valid),
   .rsp_data_check_ok  (rsp_data_check_ok),
   .rsp_last_of_frame  (rsp_last_of_frame)
);

### sim/tb_top.sv
// self-checking testbench for the xor checked frame parser: directed and random byte streams
`timescale 1ns / 1ps

module tb_top;
   import xcfp_pkg::*;

   typedef enum int {
      FR_GOOD,
      FR_BAD_DATA,
      FR_BAD_HDR,
      FR_HDR_IS_START,
      FR_CUT
   } frame_flavor_type;

   typedef struct {
      logic [15:0] ident;
      logic [15:0] kind;
      logic [5:0]  length;
      logic [7:0]  pbyte;
      logic [4:0]  pindex;
      logic        pvalid;
      logic        check_ok;
      logic        last;
      logic [31:0] good;
      logic [31:0] bad;
   } frame_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'h00;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_frame_ident;
   logic [15:0] rsp_frame_kind;
   logic [5:0]  rsp_payload_length;
   logic [7:0]  rsp_payload_byte;
   logic [4:0]  rsp_payload_index;
   logic        rsp_payload_valid;
   logic        rsp_data_check_ok;
   logic        rsp_last_of_frame;
   logic [31:0] rsp_good_frames;
   logic [31:0] rsp_bad_events;

   // stimulus and scoreboard
   logic [7:0]  rx_stream_q[$];
   frame_beat_type frame_beats_due[$];
   logic        req_taken = 1'b0;
   logic        rsp_taken = 1'b0;
   int          send_gap = 0;
   int          drain_gap = 0;
   int          calm_left = 0;
   int          bytes_made = 0;
   int          bytes_sent = 0;
   int          beats_seen = 0;
   int          frames_seen = 0;
   int          mismatches = 0;

   // parser mirror
   logic [7:0]  start_cfg = START_RESET;
   state_type   ph = ST_HUNT;
   logic [7:0]  hdr_x = 8'h00;
   logic [7:0]  pay_x = 8'h00;
   logic [15:0] ident_r = 16'h0000;
   logic [15:0] kind_r = 16'h0000;
   logic [5:0]  len_r = 6'd0;
   logic        len_hi_nz = 1'b0;
   int          fill = 0;
   logic [7:0]  pay_mem [MAX_PAYLOAD];
   logic [31:0] good_cnt = 32'd0;
   logic [31:0] bad_cnt = 32'd0;

   xor_checked_frame_parser_top u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_ident    (rsp_frame_ident),
      .rsp_frame_kind     (rsp_frame_kind),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_payload_valid  (rsp_payload_valid),
      .rsp_data_check_ok  (rsp_data_check_ok),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .rsp_good_frames    (rsp_good_frames),
      .rsp_bad_events     (rsp_bad_events)
   );

   always #5 clock = ~clock;

   // walks one received byte through the parser mirror and queues any frame beats
   function automatic void parse_byte(input logic [7:0] b);
      frame_beat_type beat;
      logic        ok;
      int          n;
      case (ph)
         ST_HUNT: begin
            if (b == start_cfg) begin
               hdr_x = b;
               ph = ST_ID_H;
            end
         end
         ST_ID_H: begin
            hdr_x ^= b;
            ident_r = {b, 8'h00};
            ph = ST_ID_L;
         end
         ST_ID_L: begin
            hdr_x ^= b;
            ident_r[7:0] = b;
            ph = ST_LEN_H;
         end
         ST_LEN_H: begin
            hdr_x ^= b;
            len_hi_nz = (b != 8'h00);
            ph = ST_LEN_L;
         end
         ST_LEN_L: begin
            hdr_x ^= b;
            // oversize length: straight back to hunting, this byte is not a start candidate
            if (len_hi_nz || b > MAX_PAYLOAD) begin
               bad_cnt++;
               ph = ST_HUNT;
            end else begin
               len_r = b[5:0];
               ph = ST_KIND_H;
            end
         end
         ST_KIND_H: begin
            hdr_x ^= b;
            kind_r = {b, 8'h00};
            ph = ST_KIND_L;
         end
         ST_KIND_L: begin
            hdr_x ^= b;
            kind_r[7:0] = b;
            ph = ST_HCHK;
         end
         ST_HCHK: begin
            if (~hdr_x != b) begin
               bad_cnt++;
               // a bad checksum byte that equals the start byte opens a new header
               if (b == start_cfg) begin
                  hdr_x = b;
                  ph = ST_ID_H;
               end else begin
                  ph = ST_HUNT;
               end
            end else begin
               fill = 0;
               pay_x = 8'h00;
               ph = (len_r != 6'd0) ? ST_DATA : ST_DCHK;
            end
         end
         ST_DATA: begin
            if (fill < MAX_PAYLOAD) pay_mem[fill] = b;
            pay_x ^= b;
            fill++;
            if (fill >= len_r) ph = ST_DCHK;
         end
         ST_DCHK: begin
            ok = (~pay_x == b);
            if (ok) good_cnt++;
            else bad_cnt++;
            ph = ST_HUNT;
            n = (len_r > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(len_r);
            beat.ident  = ident_r;
            beat.kind   = kind_r;
            beat.length = len_r;
            beat.good   = good_cnt;
            beat.bad    = bad_cnt;
            if (n == 0) begin
               beat.pbyte    = 8'h00;
               beat.pindex   = 5'd0;
               beat.pvalid   = 1'b0;
               beat.last     = 1'b1;
               beat.check_ok = ok;
               frame_beats_due.push_back(beat);
            end else begin
               for (int k = 0; k < n; k++) begin
                  beat.pbyte    = pay_mem[k];
                  beat.pindex   = k[4:0];
                  beat.pvalid   = 1'b1;
                  beat.last     = (k == n - 1);
                  beat.check_ok = beat.last && ok;
                  frame_beats_due.push_back(beat);
               end
            end
         end
         default: ph = ST_HUNT;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // idle draw shared by both sides, with occasional stretches of no idling
   function automatic int pick_wait();
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) calm_left = int'($urandom_range(10, 40));
      return int'($urandom_range(0, 6));
   endfunction

   function automatic logic [7:0] header_sum(input logic [7:0] sof, input logic [15:0] id,
                                             input logic [15:0] len16, input logic [15:0] kind);
      return ~(sof ^ id[15:8] ^ id[7:0] ^ len16[15:8] ^ len16[7:0] ^ kind[15:8] ^ kind[7:0]);
   endfunction

   function automatic logic [7:0] other_byte();
      logic [7:0] v;
      do v = 8'($urandom); while (v == start_cfg);
      return v;
   endfunction

   task automatic put_byte(input logic [7:0] b);
      rx_stream_q.push_back(b);
      bytes_made++;
   endtask

   task automatic add_frame(input logic [15:0] id, input logic [15:0] kind,
                            input logic [15:0] len16, input frame_flavor_type fl,
                            input bit with_sof = 1'b1);
      logic [7:0] hsum;
      logic [7:0] psum;
      logic [7:0] pb;
      int         cnt;
      hsum = header_sum(start_cfg, id, len16, kind);
      if (fl == FR_HDR_IS_START && hsum == start_cfg) begin
         kind[0] = ~kind[0];
         hsum = header_sum(start_cfg, id, len16, kind);
      end
      if (with_sof) put_byte(start_cfg);
      put_byte(id[15:8]);
      put_byte(id[7:0]);
      put_byte(len16[15:8]);
      put_byte(len16[7:0]);
      if (len16 > MAX_PAYLOAD) return;
      put_byte(kind[15:8]);
      put_byte(kind[7:0]);
      case (fl)
         FR_BAD_HDR: begin
            put_byte(hsum ^ 8'($urandom_range(1, 255)));
            return;
         end
         FR_HDR_IS_START: begin
            put_byte(start_cfg);
            return;
         end
         default: put_byte(hsum);
      endcase
      psum = 8'h00;
      cnt = (fl == FR_CUT) ? int'(len16) / 2 : int'(len16);
      for (int i = 0; i < cnt; i++) begin
         pb = 8'($urandom);
         psum ^= pb;
         put_byte(pb);
      end
      if (fl == FR_CUT) return;
      if (fl == FR_BAD_DATA) put_byte(~psum ^ 8'($urandom_range(1, 255)));
      else put_byte(~psum);
   endtask

   task automatic random_traffic(input int budget);
      int            target;
      int            r;
      logic [15:0]   len16;
      frame_flavor_type fl;
      bit            sof;
      target = bytes_made + budget;
      sof = 1'b1;
      while (bytes_made < target) begin
         if (sof) begin
            repeat ($urandom_range(0, 2)) put_byte(other_byte());
            // rare raw noise that may fake a start
            if ($urandom_range(0, 9) == 0) put_byte(8'($urandom));
         end
         r = int'($urandom_range(0, 99));
         if (r < 75) len16 = 16'($urandom_range(0, 8));
         else if (r < 93) len16 = 16'($urandom_range(9, 31));
         else if (r < 97) len16 = 16'(MAX_PAYLOAD);
         else if ($urandom_range(0, 1)) len16 = 16'($urandom_range(33, 255));
         else len16 = 16'($urandom_range(256, 65535));
         r = int'($urandom_range(0, 99));
         if (r < 78) fl = FR_GOOD;
         else if (r < 88) fl = FR_BAD_DATA;
         else if (r < 93) fl = FR_BAD_HDR;
         else if (r < 97) fl = FR_HDR_IS_START;
         else fl = FR_CUT;
         add_frame(16'($urandom), 16'($urandom), len16, fl, sof);
         sof = !(fl == FR_HDR_IS_START && len16 <= MAX_PAYLOAD);
      end
   endtask

   task automatic wait_drained();
      while (!(rx_stream_q.size() == 0 && !req_valid && frame_beats_due.size() == 0))
         @(posedge clock);
      // a byte with no result may still be in flight
      repeat (10) @(posedge clock);
   endtask

   task automatic write_start(input logic [7:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      start_cfg = v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // byte driver
   always @(negedge clock) begin : drive_req
      logic       nv;
      logic [7:0] nb;
      if (!reset) begin
         nv = req_valid;
         nb = req_rx_byte;
         if (req_taken) begin
            nv = 1'b0;
            send_gap = pick_wait();
         end
         if (!nv) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (rx_stream_q.size() > 0) begin
               nb = rx_stream_q.pop_front();
               nv = 1'b1;
            end
         end
         req_valid <= nv;
         req_rx_byte <= nb;
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) drain_gap = pick_wait();
         if (drain_gap > 0) begin
            drain_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: predicts on each accepted byte, checks each accepted result beat
   always @(posedge clock) begin : watch
      frame_beat_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         rsp_taken <= rsp_valid && rsp_ready;
         if (rsp_valid && rsp_ready) begin
            beats_seen++;
            if (frame_beats_due.size() == 0) begin
               $error("result beat with no expectation pending");
               mismatches++;
            end else begin
               want = frame_beats_due.pop_front();
               check_field("frame_ident", 32'(want.ident), 32'(rsp_frame_ident));
               check_field("frame_kind", 32'(want.kind), 32'(rsp_frame_kind));
               check_field("payload_length", 32'(want.length), 32'(rsp_payload_length));
               check_field("payload_byte", 32'(want.pbyte), 32'(rsp_payload_byte));
               check_field("payload_index", 32'(want.pindex), 32'(rsp_payload_index));
               check_field("payload_valid", 32'(want.pvalid), 32'(rsp_payload_valid));
               check_field("data_check_ok", 32'(want.check_ok), 32'(rsp_data_check_ok));
               check_field("last_of_frame", 32'(want.last), 32'(rsp_last_of_frame));
               check_field("good_frames", want.good, rsp_good_frames);
               check_field("bad_events", want.bad, rsp_bad_events);
               if (want.last) frames_seen++;
            end
         end
         if (req_valid && req_ready) begin
            parse_byte(req_rx_byte);
            bytes_sent++;
         end
      end
   end

   initial begin
      logic [7:0] last_start;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset start byte: field extremes and every error path
      put_byte(8'h00);
      put_byte(8'hFF);
      add_frame(16'h0000, 16'h0000, 16'd0, FR_GOOD);
      add_frame(16'hFFFF, 16'hFFFF, 16'd1, FR_GOOD);
      add_frame(16'($urandom), 16'($urandom), 16'(MAX_PAYLOAD), FR_GOOD);
      add_frame(16'($urandom), 16'($urandom), 16'd3, FR_BAD_DATA);
      add_frame(16'($urandom), 16'($urandom), 16'd2, FR_BAD_HDR);
      add_frame(16'($urandom), 16'($urandom), 16'd4, FR_HDR_IS_START);
      add_frame(16'($urandom), 16'($urandom), 16'd4, FR_GOOD, 1'b0);
      add_frame(16'($urandom), 16'($urandom), 16'(MAX_PAYLOAD + 1), FR_GOOD);
      // low length byte equals the start byte and must not resync
      add_frame(16'($urandom), 16'($urandom), 16'h0101, FR_GOOD);
      add_frame(16'($urandom), 16'($urandom), 16'hFFFF, FR_GOOD);
      add_frame(16'($urandom), 16'($urandom), 16'd5, FR_GOOD);
      wait_drained();

      write_start(8'h00);
      put_byte(8'hFF);
      add_frame(16'hFFFF, 16'h0000, 16'd0, FR_GOOD);
      random_traffic(15);
      wait_drained();

      write_start(8'hFF);
      add_frame(16'($urandom), 16'($urandom), 16'h00FF, FR_GOOD);
      add_frame(16'h0000, 16'hFFFF, 16'd5, FR_GOOD);
      random_traffic(15);
      wait_drained();

      last_start = 8'($urandom_range(2, 254));
      write_start(last_start);
      random_traffic(15);
      wait_drained();

      $display("covered %0d bytes, %0d result beats in %0d frames (%0d good, %0d bad events)",
               bytes_sent, beats_seen, frames_seen, good_cnt, bad_cnt);
      $display("start byte settings: 01, 00, ff, %02h", last_start);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d beats still due", frame_beats_due.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
